// ===== design/bms_pkg.sv =====
// shared types and constants for the bounded motion step block
`default_nettype none

package bms_pkg;

   // field widths of the object record
   localparam int POS_W  = 16;
   localparam int VEL_W  = 13;
   localparam int HALF_W = 13;
   localparam int SIZE_W = 12;

   // internal widths: stepped position with reflection headroom, velocity with negation headroom
   localparam int WIDE_W  = POS_W + 2;
   localparam int VWIDE_W = VEL_W + 1;
   localparam int BOUND_W = HALF_W + 1;

   // register indexes on the configuration port
   localparam logic CSR_HALF_WIDTH  = 1'b0;
   localparam logic CSR_HALF_HEIGHT = 1'b1;

   // reset value of both screen half extents
   localparam logic [HALF_W-1:0] HALF_RESET = 13'd127;

   // boundary modes
   typedef enum logic [1:0] {
      MODE_WRAP   = 2'd0,
      MODE_BOUNCE = 2'd1,
      MODE_VANISH = 2'd2,
      MODE_CLAMP  = 2'd3
   } mode_type;

   // per-cycle control handed to each axis pipeline
   typedef struct packed {
      logic     advance;
      mode_type mode;
   } ctl_type;

endpackage

`default_nettype wire

// ===== design/bms_axis.sv =====
// four-stage pipeline for one coordinate axis: step, upper edge, lower edge, saturate
`default_nettype none

module bms_axis
   import bms_pkg::*;
(
   input  wire logic                      clock,
   input  wire ctl_type                   ctl,
   input  wire logic signed [POS_W-1:0]   pos,
   input  wire logic signed [VEL_W-1:0]   vel,
   input  wire logic [HALF_W-1:0]         half,
   input  wire logic [SIZE_W-1:0]         size,
   output logic                           outside,
   output logic signed [POS_W-1:0]        new_pos,
   output logic signed [VEL_W-1:0]        new_vel
);

   // stage 1: stepped position and widened edge
   logic signed [WIDE_W-1:0]  s1_pos_ff, s1_pos_in;
   logic signed [VWIDE_W-1:0] s1_vel_ff, s1_vel_in;
   logic [BOUND_W-1:0]        s1_bound_ff, s1_bound_in;
   mode_type                  s1_mode_ff;

   // stage 2: after the upper edge check
   logic signed [WIDE_W-1:0]  s2_pos_ff, s2_pos_in;
   logic signed [VWIDE_W-1:0] s2_vel_ff, s2_vel_in;
   logic [BOUND_W-1:0]        s2_bound_ff;
   mode_type                  s2_mode_ff;
   logic                      s2_out_ff, s2_out_in;

   // stage 3: after the lower edge check
   logic signed [WIDE_W-1:0]  s3_pos_ff, s3_pos_in;
   logic signed [VWIDE_W-1:0] s3_vel_ff, s3_vel_in;
   logic                      s3_out_ff, s3_out_in;

   // stage 4: saturated result
   logic signed [POS_W-1:0]   new_pos_ff, new_pos_in;
   logic signed [VEL_W-1:0]   new_vel_ff, new_vel_in;

   logic signed [WIDE_W-1:0]  s1_edge, s1_twice;
   logic signed [WIDE_W-1:0]  s2_edge, s2_twice;

   // step and edge sum
   always_comb begin
      s1_pos_in   = WIDE_W'(pos) + WIDE_W'(vel);
      s1_vel_in   = VWIDE_W'(vel);
      s1_bound_in = BOUND_W'(half) + BOUND_W'(size);
   end

   // upper edge: x above right
   always_comb begin
      s1_edge   = signed'(WIDE_W'(s1_bound_ff));
      s1_twice  = s1_edge <<< 1;
      s2_pos_in = s1_pos_ff;
      s2_vel_in = s1_vel_ff;
      s2_out_in = 1'b0;
      if (s1_pos_ff > s1_edge) begin
         case (s1_mode_ff)
            MODE_WRAP: begin
               s2_pos_in = s1_pos_ff - s1_twice;
            end
            MODE_BOUNCE: begin
               s2_pos_in = s1_twice - s1_pos_ff;
               s2_vel_in = -s1_vel_ff;
            end
            MODE_VANISH: begin
               s2_out_in = 1'b1;
            end
            MODE_CLAMP: begin
               s2_pos_in = s1_edge;
               s2_vel_in = '0;
            end
            default: begin
               s2_pos_in = s1_pos_ff;
            end
         endcase
      end
   end

   // lower edge: x below left, on the values left by the upper check
   always_comb begin
      s2_edge   = signed'(WIDE_W'(s2_bound_ff));
      s2_twice  = s2_edge <<< 1;
      s3_pos_in = s2_pos_ff;
      s3_vel_in = s2_vel_ff;
      s3_out_in = s2_out_ff;
      if (s2_pos_ff < -s2_edge) begin
         case (s2_mode_ff)
            MODE_WRAP: begin
               s3_pos_in = s2_pos_ff + s2_twice;
            end
            MODE_BOUNCE: begin
               s3_pos_in = -s2_twice - s2_pos_ff;
               s3_vel_in = -s2_vel_ff;
            end
            MODE_VANISH: begin
               s3_out_in = 1'b1;
            end
            MODE_CLAMP: begin
               s3_pos_in = -s2_edge;
               s3_vel_in = '0;
            end
            default: begin
               s3_pos_in = s2_pos_ff;
            end
         endcase
      end
   end

   // saturate to the result ranges
   always_comb begin
      if (s3_pos_ff > WIDE_W'(32767)) begin
         new_pos_in = 16'sh7fff;
      end else if (s3_pos_ff < -WIDE_W'(32768)) begin
         new_pos_in = 16'sh8000;
      end else begin
         new_pos_in = s3_pos_ff[POS_W-1:0];
      end
      if (s3_vel_ff > VWIDE_W'(4095)) begin
         new_vel_in = 13'sh0fff;
      end else if (s3_vel_ff < -VWIDE_W'(4096)) begin
         new_vel_in = 13'sh1000;
      end else begin
         new_vel_in = s3_vel_ff[VEL_W-1:0];
      end
   end

   // payload registers move together when the pipeline advances
   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         s1_pos_ff   <= s1_pos_in;
         s1_vel_ff   <= s1_vel_in;
         s1_bound_ff <= s1_bound_in;
         s1_mode_ff  <= ctl.mode;
         s2_pos_ff   <= s2_pos_in;
         s2_vel_ff   <= s2_vel_in;
         s2_bound_ff <= s1_bound_ff;
         s2_mode_ff  <= s1_mode_ff;
         s2_out_ff   <= s2_out_in;
         s3_pos_ff   <= s3_pos_in;
         s3_vel_ff   <= s3_vel_in;
         s3_out_ff   <= s3_out_in;
         new_pos_ff  <= new_pos_in;
         new_vel_ff  <= new_vel_in;
      end
   end

   assign outside = s3_out_ff;
   assign new_pos = new_pos_ff;
   assign new_vel = new_vel_ff;

endmodule

`default_nettype wire

// ===== design/bounded_motion_step.sv =====
// top level of the bounded motion step: object pipeline, configuration registers, handshake
//
// One object is taken per clock while no result is stalled; its updated record is produced as the work
// runs through four register stages (step and edge sum, right/top edge check, left/bottom
// edge check, saturation into the output register), with x and y handled side by side.
// Throughput is one transfer per cycle as long as rsp_stall stays low; while a result waits
// on rsp_stall the whole pipeline holds and req_stall is raised. The screen half width and
// half height are written through the csr_ port, which is always ready, and should be
// changed only while no object is in flight.
`default_nettype none

module bounded_motion_step
   import bms_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   // object input
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic signed [POS_W-1:0]   req_pos_x,
   input  wire logic signed [POS_W-1:0]   req_pos_y,
   input  wire logic signed [VEL_W-1:0]   req_vel_x,
   input  wire logic signed [VEL_W-1:0]   req_vel_y,
   input  wire logic                      req_alive_in,
   input  wire logic [SIZE_W-1:0]         req_object_half_size,
   input  wire logic [1:0]                req_opcode,
   // updated object
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic signed [POS_W-1:0]        rsp_new_x,
   output logic signed [POS_W-1:0]        rsp_new_y,
   output logic signed [VEL_W-1:0]        rsp_new_vx,
   output logic signed [VEL_W-1:0]        rsp_new_vy,
   output logic                           rsp_alive_out,
   // configuration writes
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic                      csr_index,
   input  wire logic [HALF_W-1:0]         csr_wdata
);

   logic [HALF_W-1:0] half_w_ff, half_h_ff;
   logic              s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   logic              s1_alive_ff, s2_alive_ff, s3_alive_ff, alive_out_ff;
   logic              alive_out_in;
   logic              advance;
   logic              out_x, out_y;
   ctl_type           ctl;

   // whole pipeline holds only while a finished result is refused
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;
   assign csr_ready = 1'b1;

   assign ctl.advance = advance;
   assign ctl.mode    = mode_type'(req_opcode);

   // screen box registers
   always_ff @(posedge clock) begin
      if (reset) begin
         half_w_ff <= HALF_RESET;
         half_h_ff <= HALF_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_HALF_WIDTH:  half_w_ff <= csr_wdata;
            CSR_HALF_HEIGHT: half_h_ff <= csr_wdata;
            default:         half_w_ff <= half_w_ff;
         endcase
      end
   end

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= req_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   // alive flag, cleared by vanish when either axis left the box
   assign alive_out_in = s3_alive_ff && !(out_x || out_y);

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_alive_ff  <= req_alive_in;
         s2_alive_ff  <= s1_alive_ff;
         s3_alive_ff  <= s2_alive_ff;
         alive_out_ff <= alive_out_in;
      end
   end

   // horizontal axis
   bms_axis u_axis_x (
      .clock   (clock),
      .ctl     (ctl),
      .pos     (req_pos_x),
      .vel     (req_vel_x),
      .half    (half_w_ff),
      .size    (req_object_half_size),
      .outside (out_x),
      .new_pos (rsp_new_x),
      .new_vel (rsp_new_vx)
   );

   // vertical axis
   bms_axis u_axis_y (
      .clock   (clock),
      .ctl     (ctl),
      .pos     (req_pos_y),
      .vel     (req_vel_y),
      .half    (half_h_ff),
      .size    (req_object_half_size),
      .outside (out_y),
      .new_pos (rsp_new_y),
      .new_vel (rsp_new_vy)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_alive_out = alive_out_ff;

endmodule

`default_nettype wire

// ===== design/bms_checker.sv =====
// port-level checks for the bounded motion step, bound to the top level
`default_nettype none

module bms_checker
   import bms_pkg::*;
(
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    req_valid,
   input wire logic                    req_stall,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_stall,
   input wire logic signed [POS_W-1:0] rsp_new_x,
   input wire logic signed [POS_W-1:0] rsp_new_y,
   input wire logic signed [VEL_W-1:0] rsp_new_vx,
   input wire logic signed [VEL_W-1:0] rsp_new_vy,
   input wire logic                    rsp_alive_out
);

   // a refused result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // a refused result does not change
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_new_x) && $stable(rsp_new_y)
         && $stable(rsp_new_vx) && $stable(rsp_new_vy) && $stable(rsp_alive_out))
      else $error("stalled result changed");

   // input is held back only by a refused result
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output back pressure");

   // an accepted object comes out as long as rsp_stall stays low while it moves through the stages
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall |=> rsp_valid)
      else $error("object lost in the pipeline");

   // no result is offered right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result offered out of reset");

endmodule

bind bounded_motion_step bms_checker u_bms_checker (.*);

`default_nettype wire
